// File: rtl/hdg_pkg.sv
package hdg_pkg;

  // default CORDIC depth, legal range 8..24
  localparam int CordicStagesDef = 16;
  localparam int MaxStages = 24;

  // Q16 fixed point: 0.01 degree scaled by 2^16
  localparam int SinW = 20;
  localparam int AngW = 32;
  localparam int VecW = 56;
  localparam int HdgW = 36;

  localparam logic signed [SinW-1:0] CordicX0 = SinW'(39797);
  localparam logic signed [HdgW-1:0] FullTurn = HdgW'(64'sd2359296000);
  localparam logic signed [HdgW-1:0] HalfTurn = HdgW'(64'sd1179648000);
  localparam logic signed [16:0] DeclMax = 17'sd18000;

  // 1/100 reciprocal, scaled by 2^19
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int RecipShift = 19;

  // atan(2^-i) in 0.01 degree, Q16
  localparam logic signed [AngW-1:0] AtanTab [MaxStages] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507, 32'sd23437865,
    32'sd11730358, 32'sd5866610, 32'sd2933484, 32'sd1466764, 32'sd733385,
    32'sd366693, 32'sd183346, 32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
    32'sd5730, 32'sd2865, 32'sd1432, 32'sd716, 32'sd358, 32'sd179, 32'sd90, 32'sd45
  };

  // configuration register index (word address bit 2)
  typedef enum logic {
    CFG_DECL = 1'b0,
    CFG_TILT = 1'b1
  } cfg_idx_t;

  // control that travels alongside the arithmetic
  typedef struct packed {
    logic valid;
    logic ok;
  } side_t;

endpackage

// File: rtl/hdg_if.sv
interface hdg_in_if;
  logic valid;
  logic ready;
  logic read_ok;
  logic signed [11:0] mag_x;
  logic signed [11:0] mag_y;
  logic signed [11:0] mag_z;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;

  modport source (output valid, read_ok, mag_x, mag_y, mag_z, roll_angle, pitch_angle,
                  input ready);
  modport sink (input valid, read_ok, mag_x, mag_y, mag_z, roll_angle, pitch_angle,
                output ready);
endinterface

interface hdg_out_if;
  logic valid;
  logic ready;
  logic heading_valid;
  logic [8:0] heading_deg;

  modport source (output valid, heading_valid, heading_deg, input ready);
  modport sink (input valid, heading_valid, heading_deg, output ready);
endinterface

// File: rtl/hdg_sincos.sv
module hdg_sincos
  import hdg_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic clk,
  input  logic en,
  input  logic signed [AngW-1:0] z_in,
  input  logic neg_in,
  output logic signed [SinW-1:0] sin_out,
  output logic signed [SinW-1:0] cos_out
);

  logic signed [SinW-1:0] xs [CORDIC_STAGES+1];
  logic signed [SinW-1:0] ys [CORDIC_STAGES+1];
  logic signed [AngW-1:0] zs [CORDIC_STAGES+1];
  logic negs [CORDIC_STAGES+1];

  assign xs[0] = CordicX0;
  assign ys[0] = '0;
  assign zs[0] = z_in;
  assign negs[0] = neg_in;

  // one rotation step per register stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        negs[i+1] <= negs[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - AtanTab[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + AtanTab[i];
        end
      end
    end
  end

  // undo the half-turn fold
  assign sin_out = negs[CORDIC_STAGES] ? -ys[CORDIC_STAGES] : ys[CORDIC_STAGES];
  assign cos_out = negs[CORDIC_STAGES] ? -xs[CORDIC_STAGES] : xs[CORDIC_STAGES];

endmodule

// File: rtl/hdg_atan.sv
module hdg_atan
  import hdg_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic clk,
  input  logic en,
  input  logic signed [VecW-1:0] x_in,
  input  logic signed [VecW-1:0] y_in,
  output logic signed [AngW-1:0] z_out
);

  logic signed [VecW-1:0] xs [CORDIC_STAGES+1];
  logic signed [VecW-1:0] ys [CORDIC_STAGES+1];
  logic signed [AngW-1:0] zs [CORDIC_STAGES+1];
  logic dn [CORDIC_STAGES+1];

  // left half plane is folded by a half turn
  always_ff @(posedge clk) begin
    if (en) begin
      dn[0] <= (y_in == '0);
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= (y_in >= 0) ? AngW'(HalfTurn) : -AngW'(HalfTurn);
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  // vectoring steps, frozen once y reaches zero
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [VecW-1:0] xn;
    logic signed [VecW-1:0] yn;
    logic signed [AngW-1:0] zn;

    always_comb begin
      if (dn[i]) begin
        xn = xs[i];
        yn = ys[i];
        zn = zs[i];
      end else if (ys[i] > 0) begin
        xn = xs[i] + (ys[i] >>> i);
        yn = ys[i] - (xs[i] >>> i);
        zn = zs[i] + AtanTab[i];
      end else begin
        xn = xs[i] - (ys[i] >>> i);
        yn = ys[i] + (xs[i] >>> i);
        zn = zs[i] - AtanTab[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1] <= xn;
        ys[i+1] <= yn;
        zs[i+1] <= zn;
        dn[i+1] <= dn[i] || (yn == '0);
      end
    end
  end

  assign z_out = zs[CORDIC_STAGES];

endmodule

// File: rtl/tilt_compensated_heading.sv
// Tilt-compensated compass heading.
// Samples arrive on samp (valid/ready); one result leaves on hdg for every
// sample, in order. A sample with read_ok low or |roll| or |pitch| above
// tilt_limit gives heading_valid 0 and heading_deg 0; otherwise heading_deg
// is the tilt-compensated heading plus declination, whole degrees 0..360.
// Registers on the APB port: declination at 0x0, tilt_limit at 0x4; write
// them only while no sample is in flight.
// The stages are an input register, the sine/cosine CORDIC, three
// multiply/sum stages, the atan2 CORDIC with its fold stage, and three
// stages of wrap and scaling. Throughput is one sample per cycle unless
// the output stalls. The whole pipeline advances together: when
// hdg.ready is low with a result held, every stage holds and samp.ready
// drops until the result is taken; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads declination 0,
// tilt_limit 4000.
module tilt_compensated_heading
  import hdg_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  hdg_in_if.sink samp,
  hdg_out_if.source hdg
);

  logic signed [15:0] declination;
  logic [14:0] tilt_limit;
  logic en;
  cfg_idx_t cfg_sel;

  // config registers
  assign pready = 1'b1;
  assign cfg_sel = cfg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= '0;
      tilt_limit <= 15'd4000;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        CFG_DECL: declination <= pwdata[15:0];
        CFG_TILT: tilt_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_DECL: prdata = {{16{declination[15]}}, declination};
      CFG_TILT: prdata = {17'd0, tilt_limit};
      default: prdata = '0;
    endcase
  end

  // global advance
  assign en = !hdg.valid || hdg.ready;
  assign samp.ready = en;

  // angle wrap and fold into +-90 degrees
  function automatic logic [AngW:0] fold(input logic signed [15:0] a);
    logic signed [17:0] c;
    logic neg;
    c = 18'(a);
    neg = 1'b0;
    if (c > 18'sd18000) c = c - 18'sd36000;
    if (c < -18'sd18000) c = c + 18'sd36000;
    if (c > 18'sd9000) begin
      c = c - 18'sd18000;
      neg = 1'b1;
    end else if (c < -18'sd9000) begin
      c = c + 18'sd18000;
      neg = 1'b1;
    end
    return {neg, AngW'(c) <<< 16};
  endfunction

  // input stage
  logic signed [16:0] lim;
  logic tilt_ok;
  logic [AngW:0] fr;
  logic [AngW:0] fp;
  side_t s0;
  logic signed [11:0] mx0, my0, mz0;
  logic signed [AngW-1:0] zr0, zp0;
  logic nr0, np0;

  assign lim = 17'(tilt_limit);
  assign tilt_ok = (17'(samp.roll_angle) <= lim) && (17'(samp.roll_angle) >= -lim) &&
                   (17'(samp.pitch_angle) <= lim) && (17'(samp.pitch_angle) >= -lim);
  assign fr = fold(samp.roll_angle);
  assign fp = fold(samp.pitch_angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= '0;
    end else if (en) begin
      s0.valid <= samp.valid;
      s0.ok <= samp.read_ok && tilt_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx0 <= samp.mag_x;
      my0 <= samp.mag_y;
      mz0 <= samp.mag_z;
      zr0 <= fr[AngW-1:0];
      nr0 <= fr[AngW];
      zp0 <= fp[AngW-1:0];
      np0 <= fp[AngW];
    end
  end

  // sine/cosine: pitch gives the "roll" terms, roll the "pitch" terms
  logic signed [SinW-1:0] sr, cr, sp, cp;

  hdg_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_pitch (
    .clk(clk), .en(en), .z_in(zp0), .neg_in(np0), .sin_out(sr), .cos_out(cr)
  );

  hdg_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_roll (
    .clk(clk), .en(en), .z_in(zr0), .neg_in(nr0), .sin_out(sp), .cos_out(cp)
  );

  // sidecar delay across the sine/cosine CORDIC
  side_t sd [CORDIC_STAGES+1];
  logic signed [11:0] mxd [CORDIC_STAGES+1];
  logic signed [11:0] myd [CORDIC_STAGES+1];
  logic signed [11:0] mzd [CORDIC_STAGES+1];

  assign sd[0] = s0;
  assign mxd[0] = mx0;
  assign myd[0] = my0;
  assign mzd[0] = mz0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1] <= '0;
      end else if (en) begin
        sd[i+1] <= sd[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        mxd[i+1] <= mxd[i];
        myd[i+1] <= myd[i];
        mzd[i+1] <= mzd[i];
      end
    end
  end

  // products, first level
  side_t sa, sb, sc;
  logic signed [39:0] p_ss, p_sc;
  logic signed [31:0] mxcp, mzsp, mycr;
  logic signed [11:0] mxa, mza;
  logic signed [51:0] t1, t2;
  logic signed [48:0] xhb;
  logic signed [47:0] ycrb;
  logic signed [VecW-1:0] xh, yh;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa <= '0;
      sb <= '0;
      sc <= '0;
    end else if (en) begin
      sa <= sd[CORDIC_STAGES];
      sb <= sa;
      sc <= sb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ss <= 40'(sr) * 40'(sp);
      p_sc <= 40'(sr) * 40'(cp);
      mxcp <= 32'(mxd[CORDIC_STAGES]) * 32'(cp);
      mzsp <= 32'(mzd[CORDIC_STAGES]) * 32'(sp);
      mycr <= 32'(myd[CORDIC_STAGES]) * 32'(cr);
      mxa <= mxd[CORDIC_STAGES];
      mza <= mzd[CORDIC_STAGES];
    end
  end

  // products, second level
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= 52'(mxa) * 52'(p_ss);
      t2 <= 52'(mza) * 52'(p_sc);
      xhb <= (49'(mxcp) + 49'(mzsp)) <<< 16;
      ycrb <= 48'(mycr) <<< 16;
    end
  end

  // horizontal components
  always_ff @(posedge clk) begin
    if (en) begin
      xh <= VecW'(xhb);
      yh <= VecW'(t1) + VecW'(ycrb) - VecW'(t2);
    end
  end

  logic signed [AngW-1:0] zat;

  hdg_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan (
    .clk(clk), .en(en), .x_in(xh), .y_in(yh), .z_out(zat)
  );

  // sidecar delay across the atan2 CORDIC
  side_t sv [CORDIC_STAGES+2];
  assign sv[0] = sc;

  for (genvar i = 0; i < CORDIC_STAGES + 1; i++) begin : g_sv
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= '0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end
  end

  // heading with declination, wrapped once
  logic signed [16:0] dsat;
  logic signed [HdgW-1:0] h_raw, h_w1, h_w2, h1;
  side_t s1, s2;

  always_comb begin
    dsat = 17'(declination);
    if (dsat > DeclMax) dsat = DeclMax;
    if (dsat < -DeclMax) dsat = -DeclMax;
    h_raw = -HdgW'(zat) + (HdgW'(dsat) <<< 16);
    h_w1 = (h_raw < 0) ? h_raw + FullTurn : h_raw;
    h_w2 = (h_w1 > FullTurn) ? h_w1 - FullTurn : h_w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else if (en) begin
      s1 <= sv[CORDIC_STAGES+1];
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= h_w2;
    end
  end

  // truncating divide by 100*2^16: shift, then reciprocal estimate
  logic [HdgW-1:0] hmag;
  logic [17:0] v1;
  logic [17:0] v2;
  logic [12:0] q2;
  logic neg2;
  logic [31:0] qprod;

  assign hmag = (h1 < 0) ? HdgW'(-h1) : HdgW'(h1);
  assign v1 = hmag[33:16];
  assign qprod = 32'(v1) * 32'(Recip100);

  always_ff @(posedge clk) begin
    if (en) begin
      v2 <= v1;
      q2 <= qprod[RecipShift +: 13];
      neg2 <= h1 < 0;
    end
  end

  // correct the estimate and drive the output register
  logic [19:0] q100;
  logic [12:0] qf;
  logic [12:0] qs;

  assign q100 = 20'(q2) * 20'd100;
  assign qf = (q100 > 20'(v2)) ? q2 - 13'd1 : q2;
  assign qs = neg2 ? -qf : qf;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdg.valid <= 1'b0;
    end else if (en) begin
      hdg.valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hdg.heading_valid <= s2.ok;
      hdg.heading_deg <= s2.ok ? qs[8:0] : 9'd0;
    end
  end

  // checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !hdg.valid)
    else $error("result presented right after reset");
  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    hdg.valid && !hdg.heading_valid |-> hdg.heading_deg == 9'd0)
    else $error("invalid result carries a heading");
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    hdg.valid && !hdg.ready |-> !samp.ready)
    else $error("sample accepted while pipeline is stalled");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s2.valid && !en |=> s2.valid)
    else $error("item dropped from last pipeline stage during stall");

endmodule

// File: test/tb_tilt_compensated_heading.sv
`timescale 1ns / 1ps

module tb_tilt_compensated_heading
  import hdg_pkg::*;
();

  localparam int NStages = 16;
  localparam longint Q16 = 65536;
  localparam longint TurnQ = 36000 * Q16;

  typedef struct {
    logic read_ok;
    logic signed [11:0] mx, my, mz;
    logic signed [15:0] roll, pitch;
  } sample_t;

  typedef struct {
    logic hv;
    logic [8:0] deg;
  } heading_t;

  // atan(2^-i), 0.01 degree in Q16
  localparam longint ArcTab [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358, 5866610,
    2933484, 1466764, 733385, 366693, 183346, 91673, 45837, 22918, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45
  };

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hdg_in_if samp_if ();
  hdg_out_if hdg_if ();

  tilt_compensated_heading dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .samp(samp_if), .hdg(hdg_if)
  );

  always #10 clk = ~clk;

  sample_t pend_q[$];
  heading_t heading_q[$];
  int errors = 0;
  logic signed [15:0] decl_reg = 16'sd0;
  logic [14:0] tilt_reg = 15'd4000;

  // rotation cordic, sine and cosine in Q16
  function automatic void rot_sin_cos(input longint cd, output longint s, output longint c);
    longint x, y, z, nx;
    bit neg;
    x = 39797; y = 0; neg = 0;
    if (cd > 18000) cd -= 36000;
    if (cd < -18000) cd += 36000;
    if (cd > 9000) begin
      cd -= 18000; neg = 1;
    end else if (cd < -9000) begin
      cd += 18000; neg = 1;
    end
    z = cd * Q16;
    for (int i = 0; i < NStages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ArcTab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ArcTab[i];
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  // vectoring cordic, angle in Q16 0.01 degree
  function automatic longint vec_atan2(input longint y, input longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 18000 * Q16 : -18000 * Q16;
      x = -x; y = -y;
    end
    for (int i = 0; i < NStages && y != 0; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ArcTab[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ArcTab[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic heading_t calc_heading(input sample_t sm);
    heading_t r;
    longint lim, roll, pitch, sp, cp, sr, cr, xh, yh, h, d, mx, my, mz;
    r.hv = 0; r.deg = '0;
    lim = tilt_reg; roll = sm.roll; pitch = sm.pitch;
    mx = sm.mx; my = sm.my; mz = sm.mz;
    if (!sm.read_ok) return r;
    if (roll > lim || roll < -lim || pitch > lim || pitch < -lim) return r;
    rot_sin_cos(pitch, sr, cr);
    rot_sin_cos(roll, sp, cp);
    xh = (mx * cp + mz * sp) * Q16;
    yh = mx * sr * sp + my * cr * Q16 - mz * sr * cp;
    d = decl_reg;
    if (d > 18000) d = 18000;
    if (d < -18000) d = -18000;
    h = -vec_atan2(yh, xh) + d * Q16;
    if (h < 0) h += TurnQ;
    if (h > TurnQ) h -= TurnQ;
    r.hv = 1;
    r.deg = 9'(h / (100 * Q16));
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      samp_if.valid <= 0;
      samp_if.read_ok <= 0;
      samp_if.mag_x <= '0; samp_if.mag_y <= '0; samp_if.mag_z <= '0;
      samp_if.roll_angle <= '0; samp_if.pitch_angle <= '0;
    end else if (!samp_if.valid || samp_if.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        samp_if.valid <= 0;
      end else if (pend_q.size() > 0) begin
        sample_t sm;
        sm = pend_q.pop_front();
        samp_if.valid <= 1;
        samp_if.read_ok <= sm.read_ok;
        samp_if.mag_x <= sm.mx; samp_if.mag_y <= sm.my; samp_if.mag_z <= sm.mz;
        samp_if.roll_angle <= sm.roll; samp_if.pitch_angle <= sm.pitch;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        samp_if.valid <= 0;
      end
    end
  end

  // receiver: ready follows a stall mode redrawn at random from three modes
  int rx_cycle = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      hdg_if.ready <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: hdg_if.ready <= 1;
        1: hdg_if.ready <= $urandom_range(0, 1);
        default: hdg_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // monitor: predict on accepted samples, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (samp_if.valid && samp_if.ready) begin
        sample_t sm;
        sm.read_ok = samp_if.read_ok;
        sm.mx = samp_if.mag_x; sm.my = samp_if.mag_y; sm.mz = samp_if.mag_z;
        sm.roll = samp_if.roll_angle; sm.pitch = samp_if.pitch_angle;
        heading_q.push_back(calc_heading(sm));
      end
      if (hdg_if.valid && hdg_if.ready) begin
        heading_t e;
        if (heading_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected heading item hv=%0d deg=%0d",
                                     hdg_if.heading_valid, hdg_if.heading_deg);
        end else begin
          e = heading_q.pop_front();
          if (e.hv !== hdg_if.heading_valid || e.deg !== hdg_if.heading_deg) begin
            errors++;
            if (errors <= 10) $display("mismatch: exp hv=%0d deg=%0d got hv=%0d deg=%0d",
                                       e.hv, e.deg, hdg_if.heading_valid, hdg_if.heading_deg);
          end
        end
      end
    end
  end

  task automatic add_sample(input logic ok, input int x, input int y, input int z,
                            input int r, input int p);
    sample_t sm;
    sm.read_ok = ok; sm.mx = 12'(x); sm.my = 12'(y); sm.mz = 12'(z);
    sm.roll = 16'(r); sm.pitch = 16'(p);
    pend_q.push_back(sm);
  endtask

  // sample the queues away from the rising edge so driver updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pend_q.size() > 0 || heading_q.size() > 0 || samp_if.valid);
    repeat (50) @(posedge clk);
  endtask

  task automatic apb_write(input cfg_idx_t idx, input logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == CFG_DECL) decl_reg = val[15:0];
    else tilt_reg = val[14:0];
  endtask

  function automatic int rand_angle(input int lim);
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return int'($urandom_range(0, 2 * lim)) - lim;
    if (k == 7) return ($urandom_range(0, 1) != 0) ? lim : -lim;
    return int'(16'($urandom));
  endfunction

  function automatic int rand_mag();
    case ($urandom_range(0, 7))
      0: return -2048;
      1: return 2047;
      2: return 0;
      default: return int'(12'($urandom));
    endcase
  endfunction

  task automatic add_random(input int count);
    int lim;
    lim = tilt_reg;
    repeat (count)
      add_sample($urandom_range(0, 9) != 0, rand_mag(), rand_mag(), rand_mag(),
                 rand_angle(lim), rand_angle(lim));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset settings
    add_sample(1, 2047, 2047, 2047, 0, 0);
    add_sample(1, -2048, -2048, -2048, 0, 0);
    add_sample(1, 0, 0, 0, 0, 0);
    add_sample(1, -100, 0, 0, 0, 0);
    add_sample(1, 100, 0, 0, 0, 0);
    add_sample(1, 0, 500, 0, 0, 0);
    add_sample(1, 0, -500, 0, 0, 0);
    add_sample(0, 300, 200, 100, 0, 0);
    add_sample(1, 300, 200, 100, 4000, -4000);
    add_sample(1, 300, 200, 100, -4000, 4000);
    add_sample(1, 300, 200, 100, 4001, 0);
    add_sample(1, 300, 200, 100, 0, -4001);
    add_sample(1, 1000, -700, 900, 2500, 1500);
    add_sample(1, -2048, 2047, -2048, -3999, 3999);
    add_random(60);
    wait_idle();

    // tilt limit 18000 and largest effective declination (the DeclMax clamp)
    apb_write(CFG_TILT, 32'd18000);
    apb_write(CFG_DECL, 32'd18000);
    add_sample(1, 300, 200, 100, 18000, -18000);
    add_sample(1, -300, 200, 100, 9001, -9001);
    add_random(80);
    wait_idle();

    // no tilt allowed, most negative unclamped declination
    apb_write(CFG_TILT, 32'd0);
    apb_write(CFG_DECL, 32'hFFFF_B9B0);
    add_sample(1, 300, 200, 100, 0, 0);
    add_sample(1, 300, 200, 100, 1, 0);
    add_random(60);
    wait_idle();

    // register extremes: angle wrap and declination saturation
    apb_write(CFG_TILT, 32'h7FFF);
    apb_write(CFG_DECL, 32'h7FFF);
    add_sample(1, 500, -300, 200, 32767, -32767);
    add_sample(1, 500, -300, 200, -32768, 0);
    add_random(80);
    wait_idle();
    apb_write(CFG_DECL, 32'h8000);
    add_random(60);
    wait_idle();

    apb_write(CFG_TILT, 32'd6000);
    apb_write(CFG_DECL, 32'hFFFF_FC18);
    add_random(60);
    wait_idle();

    if (errors == 0) begin
      $display("PASS tilt_compensated_heading");
    end else begin
      $display("FAIL tilt_compensated_heading");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL tilt_compensated_heading");
    $finish;
  end

endmodule

// File: sim.f
rtl/hdg_pkg.sv
rtl/hdg_if.sv
rtl/hdg_sincos.sv
rtl/hdg_atan.sv
rtl/tilt_compensated_heading.sv
test/tb_tilt_compensated_heading.sv
